### src/ordered_list_move_to_front_macros.svh
// Assertion macros shared by the list checker.
`ifndef ORDERED_LIST_MOVE_TO_FRONT_MACROS_SVH
`define ORDERED_LIST_MOVE_TO_FRONT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define OLMTF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("olmtf check failed");

// Next-cycle implication, off while in reset.
`define OLMTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("olmtf check failed");

`endif

### src/olmtf_pkg.sv
// Types, codes and constants for the move-to-front list.
`timescale 1ns / 1ps

package olmtf_pkg;

	localparam int DEFAULT_DEPTH = 16;
	localparam int VALUE_W       = 32;
	localparam int OPCODE_W      = 3;
	localparam int STATUS_W      = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_READ   = 3'd0,
		OP_APPEND = 3'd1,
		OP_REMOVE = 3'd2,
		OP_FRONT  = 3'd3,
		OP_BACK   = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast to every cell of the row
	typedef struct packed {
		logic               append;
		logic               remove;
		logic               front;
		logic               back;
		logic [VALUE_W-1:0] value;
		logic [VALUE_W-1:0] moved;
		logic [VALUE_W-1:0] last;
	} cell_ctrl_t;

endpackage

### src/olmtf_cell.sv
// One list slot: holds an entry and loads from its neighbours or the broadcast.
`timescale 1ns / 1ps

module olmtf_cell #(
	parameter int IDX   = 0,
	parameter int POS_W = 4,
	parameter int CNT_W = 5
) (
	input  logic                           clk,
	input  olmtf_pkg::cell_ctrl_t          ctrl,
	input  logic [POS_W-1:0]               pos,
	input  logic [CNT_W-1:0]               fill,
	input  logic [olmtf_pkg::VALUE_W-1:0]  left_entry,
	input  logic [olmtf_pkg::VALUE_W-1:0]  right_entry,
	output logic [olmtf_pkg::VALUE_W-1:0]  entry
);
	import olmtf_pkg::*;

	localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

	logic [CNT_W-1:0]   pos_ext;
	logic               load;
	logic [VALUE_W-1:0] load_val;
	logic [VALUE_W-1:0] entry_q;

	assign pos_ext = CNT_W'(pos);

	always_comb begin
		load     = 1'b0;
		load_val = ctrl.value;
		if (ctrl.append && fill == IDX_C) begin
			load = 1'b1;
		end else if (ctrl.remove && pos_ext == IDX_C) begin
			load     = 1'b1;
			load_val = ctrl.last;
		end else if (ctrl.front) begin
			if (IDX == 0) begin
				load     = 1'b1;
				load_val = ctrl.moved;
			end else if (IDX_C <= pos_ext) begin
				load     = 1'b1;
				load_val = left_entry;
			end
		end else if (ctrl.back) begin
			// last occupied slot takes the moved entry, those from pos on shift down
			if (IDX_P1 == fill) begin
				load     = 1'b1;
				load_val = ctrl.moved;
			end else if (IDX_C >= pos_ext && IDX_P1 < fill) begin
				load     = 1'b1;
				load_val = right_entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_val;
		end
	end

	assign entry = entry_q;

endmodule

### src/ordered_list_move_to_front.sv
// Top level of the move-to-front list: decode, fill count, cell row, result register.
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells.
// Every operation (read, append, remove, bring to front, send to back) is
// carried out at once: all cells load from their neighbours together, so one
// item can be accepted per clock and its result appears in the output register
// on the next cycle. The only throttle is that register: a new item is taken
// while the previous result is being taken or once it has gone. Each item gives
// exactly one result. After reset the list is empty; no clearing pass is needed.
module ordered_list_move_to_front #(
	parameter int DEPTH = olmtf_pkg::DEFAULT_DEPTH,
	localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int IN_W  =
		((olmtf_pkg::OPCODE_W + POS_W + olmtf_pkg::VALUE_W + 7) / 8) * 8,
	localparam int OUT_W =
		((olmtf_pkg::VALUE_W + CNT_W + olmtf_pkg::STATUS_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // opcode, position, value
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // read_value, count, status
);
	import olmtf_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic                  accept;
	op_t                   op;
	logic [POS_W-1:0]      pos_in;
	logic [VALUE_W-1:0]    value_in;
	logic [CNT_W-1:0]      pos_ext;
	logic                  in_range;
	logic                  full;
	cell_ctrl_t            ctrl;
	logic [VALUE_W-1:0]    moved_w;
	logic [VALUE_W-1:0]    last_w;
	logic [VALUE_W-1:0]    entry_w [DEPTH];
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      fill_d;
	status_t               status_d;
	logic [VALUE_W-1:0]    rd_d;
	logic                  m_valid_q;
	logic [OUT_W-1:0]      m_data_q;

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign op       = op_t'(s_tdata[OPCODE_W-1:0]);
	assign pos_in   = s_tdata[OPCODE_W +: POS_W];
	assign value_in = s_tdata[OPCODE_W + POS_W +: VALUE_W];
	assign pos_ext  = CNT_W'(pos_in);
	assign in_range = pos_ext < fill_q;
	assign full     = fill_q == DEPTH_C;

	// entry at the addressed position and the last occupied entry
	always_comb begin
		moved_w = '0;
		last_w  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (pos_ext == CNT_W'(i)) begin
				moved_w |= entry_w[i];
			end
			if (fill_q == CNT_W'(i + 1)) begin
				last_w |= entry_w[i];
			end
		end
	end

	always_comb begin
		ctrl       = '0;
		ctrl.value = value_in;
		ctrl.moved = moved_w;
		ctrl.last  = last_w;
		fill_d     = fill_q;
		status_d   = ST_OK;
		rd_d       = '0;
		unique case (op)
			OP_READ: begin
				if (in_range) begin
					rd_d = moved_w;
				end else begin
					status_d = ST_RANGE;
				end
			end
			OP_APPEND: begin
				if (!full) begin
					ctrl.append = accept;
					fill_d      = fill_q + CNT_W'(1);
				end else begin
					status_d = ST_FULL;
				end
			end
			OP_REMOVE: begin
				if (in_range) begin
					ctrl.remove = accept;
					fill_d      = fill_q - CNT_W'(1);
				end else begin
					status_d = ST_RANGE;
				end
			end
			OP_FRONT: begin
				if (in_range) begin
					ctrl.front = accept;
				end else begin
					status_d = ST_RANGE;
				end
			end
			OP_BACK: begin
				if (in_range) begin
					ctrl.back = accept;
				end else begin
					status_d = ST_RANGE;
				end
			end
			default: ;
		endcase
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [VALUE_W-1:0] left_w;
		logic [VALUE_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry_w[g+1];
		end

		olmtf_cell #(
			.IDX   (g),
			.POS_W (POS_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.pos         (pos_in),
			.fill        (fill_q),
			.left_entry  (left_w),
			.right_entry (right_w),
			.entry       (entry_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_d;
			end
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= OUT_W'({status_d, fill_d, rd_d});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

### src/olmtf_chk.sv
// Port-level checker for the move-to-front list, bound to the top level.
`timescale 1ns / 1ps
`include "ordered_list_move_to_front_macros.svh"

module olmtf_chk #(
	parameter int DEPTH = olmtf_pkg::DEFAULT_DEPTH,
	localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int IN_W  =
		((olmtf_pkg::OPCODE_W + POS_W + olmtf_pkg::VALUE_W + 7) / 8) * 8,
	localparam int OUT_W =
		((olmtf_pkg::VALUE_W + CNT_W + olmtf_pkg::STATUS_W + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,   // opcode, position, value
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata    // read_value, count, status
);
	import olmtf_pkg::*;

	logic [VALUE_W-1:0]  rd_value;
	logic [CNT_W-1:0]    count;
	logic [STATUS_W-1:0] status;
	logic [OPCODE_W-1:0] opcode;

	assign rd_value = m_tdata[VALUE_W-1:0];
	assign count    = m_tdata[VALUE_W +: CNT_W];
	assign status   = m_tdata[VALUE_W + CNT_W +: STATUS_W];
	assign opcode   = s_tdata[OPCODE_W-1:0];

	`OLMTF_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`OLMTF_ASSERT_NEXT(a_result, clk, arst_n, s_tvalid && s_tready, m_tvalid)
	`OLMTF_ASSERT_IMPL(a_count, clk, arst_n, m_tvalid, count <= CNT_W'(DEPTH))
	`OLMTF_ASSERT_IMPL(a_full, clk, arst_n, m_tvalid && status == ST_FULL, count == CNT_W'(DEPTH))
	`OLMTF_ASSERT_NEXT(a_append, clk, arst_n, s_tvalid && s_tready && opcode == OP_APPEND, rd_value == '0)

endmodule

bind ordered_list_move_to_front olmtf_chk #(.DEPTH(DEPTH)) u_olmtf_chk (.*);
